/* design/u8v_pkg.sv */
// Shared types and constants for the UTF-8 validator with UTF-16 unit count.
package u8v_pkg;

    localparam int unsigned DataW   = 8;
    localparam int unsigned CountW  = 16;
    localparam int unsigned ScalarW = 21;
    localparam int unsigned PendW   = 2;
    localparam int unsigned ClassW  = 2;
    localparam int unsigned ApbDataW = 32;
    localparam int unsigned ApbAddrW = 3;

    localparam logic [CountW-1:0]  MaxUnitsReset = 16'd255;
    localparam logic [ScalarW-1:0] ScalarMax     = 21'h10FFFF;
    localparam logic [ScalarW-1:0] SurrogateLo   = 21'h00D800;
    localparam logic [ScalarW-1:0] SurrogateHi   = 21'h00DFFF;
    localparam logic [ScalarW-1:0] BmpMax        = 21'h00FFFF;

    localparam logic [0:0] RegMaxUnits = 1'b0;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_ENC  = 2'd1,
        STAT_TOO_LONG = 2'd2
    } t_status;

    typedef enum logic [ClassW-1:0] {
        CLS_NONE = 2'd0,
        CLS_2B   = 2'd1,
        CLS_3B   = 2'd2,
        CLS_4B   = 2'd3
    } t_class;

    typedef struct packed {
        t_status             status;
        logic [CountW-1:0]   unit_count;
        logic                string_end;
    } t_result;

    function automatic logic [ScalarW-1:0] class_minimum(input t_class cls);
        logic [ScalarW-1:0] v;
        unique case (cls)
            CLS_2B:  v = 21'h000080;
            CLS_3B:  v = 21'h000800;
            CLS_4B:  v = 21'h010000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/u8v_cfg.sv */
// APB register block holding the UTF-16 unit limit.
module u8v_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [u8v_pkg::ApbAddrW-1:0]      paddr,
    input  logic [u8v_pkg::ApbDataW-1:0]      pwdata,
    output logic [u8v_pkg::ApbDataW-1:0]      prdata,
    output logic                              pready,
    output logic [u8v_pkg::CountW-1:0]        o_max_units
);

    logic [u8v_pkg::CountW-1:0] r_max_units;
    logic [u8v_pkg::CountW-1:0] n_max_units;
    logic                       sel_max;

    assign pready  = 1'b1;
    assign sel_max = (paddr[u8v_pkg::ApbAddrW-1] == u8v_pkg::RegMaxUnits);

    always_comb begin
        n_max_units = r_max_units;
        if (psel && penable && pwrite && pready && sel_max) begin
            n_max_units = pwdata[u8v_pkg::CountW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= u8v_pkg::MaxUnitsReset;
        end else begin
            r_max_units <= n_max_units;
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_max) begin
            prdata = {{(u8v_pkg::ApbDataW-u8v_pkg::CountW){1'b0}}, r_max_units};
        end
    end

    assign o_max_units = r_max_units;

endmodule

/* design/u8v_step.sv */
// Per-byte decode, scalar checks, unit count and string state registers.
module u8v_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [u8v_pkg::DataW-1:0]     i_data_byte,
    input  logic                          i_last_byte,
    input  logic [u8v_pkg::CountW-1:0]    i_max_units,
    output u8v_pkg::t_result              o_result
);

    logic [u8v_pkg::PendW-1:0]   r_pending, n_pending;
    logic [u8v_pkg::ScalarW-1:0] r_accum,   n_accum;
    u8v_pkg::t_class             r_cls,     n_cls;
    logic [u8v_pkg::CountW-1:0]  r_units,   n_units;
    u8v_pkg::t_status            r_err,     n_err;

    logic [u8v_pkg::ScalarW-1:0] acc_shift;
    logic [u8v_pkg::ScalarW-1:0] cp;
    u8v_pkg::t_class             cp_cls;
    logic                        cp_bad;
    logic                        cp_wide;
    logic [u8v_pkg::CountW:0]    unit_sum;
    logic                        cp_over;
    logic                        fin;

    assign acc_shift = {r_accum[u8v_pkg::ScalarW-7:0], i_data_byte[5:0]};
    assign cp        = (r_pending == '0)
                     ? {{(u8v_pkg::ScalarW-u8v_pkg::DataW){1'b0}}, i_data_byte}
                     : acc_shift;
    assign cp_cls    = (r_pending == '0) ? u8v_pkg::CLS_NONE : r_cls;
    assign cp_bad    = (cp < u8v_pkg::class_minimum(cp_cls)) || (cp > u8v_pkg::ScalarMax) ||
                       ((cp >= u8v_pkg::SurrogateLo) && (cp <= u8v_pkg::SurrogateHi));
    assign cp_wide   = (cp > u8v_pkg::BmpMax);
    assign unit_sum  = {1'b0, r_units} + (cp_wide ? 17'd2 : 17'd1);
    assign cp_over   = (unit_sum > {1'b0, i_max_units});

    always_comb begin
        n_pending = r_pending;
        n_accum   = r_accum;
        n_cls     = r_cls;
        n_units   = r_units;
        n_err     = r_err;
        fin       = 1'b0;
        if (i_accept && (r_err == u8v_pkg::STAT_OK)) begin
            if (r_pending == '0) begin
                if (i_data_byte[7] == 1'b0) begin
                    fin = 1'b1;
                end else if (i_data_byte[7:5] == 3'b110) begin
                    n_accum   = {16'd0, i_data_byte[4:0]};
                    n_pending = 2'd1;
                    n_cls     = u8v_pkg::CLS_2B;
                end else if (i_data_byte[7:4] == 4'b1110) begin
                    n_accum   = {17'd0, i_data_byte[3:0]};
                    n_pending = 2'd2;
                    n_cls     = u8v_pkg::CLS_3B;
                end else if (i_data_byte[7:3] == 5'b11110) begin
                    n_accum   = {18'd0, i_data_byte[2:0]};
                    n_pending = 2'd3;
                    n_cls     = u8v_pkg::CLS_4B;
                end else begin
                    n_err = u8v_pkg::STAT_BAD_ENC;
                end
            end else if (i_data_byte[7:6] != 2'b10) begin
                n_err = u8v_pkg::STAT_BAD_ENC;
            end else begin
                n_accum   = acc_shift;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    fin     = 1'b1;
                    n_accum = '0;
                    n_cls   = u8v_pkg::CLS_NONE;
                end
            end
            if (fin) begin
                if (cp_bad) begin
                    n_err = u8v_pkg::STAT_BAD_ENC;
                end else if (cp_over) begin
                    n_err = u8v_pkg::STAT_TOO_LONG;
                end else begin
                    n_units = unit_sum[u8v_pkg::CountW-1:0];
                end
            end
            if (i_last_byte && (n_err == u8v_pkg::STAT_OK) && (n_pending != '0)) begin
                n_err = u8v_pkg::STAT_BAD_ENC;
            end
        end
        o_result.status     = n_err;
        o_result.unit_count = n_units;
        o_result.string_end = i_last_byte;
        if (i_accept && i_last_byte) begin
            n_pending = '0;
            n_accum   = '0;
            n_cls     = u8v_pkg::CLS_NONE;
            n_units   = '0;
            n_err     = u8v_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_accum   <= '0;
            r_cls     <= u8v_pkg::CLS_NONE;
            r_units   <= '0;
            r_err     <= u8v_pkg::STAT_OK;
        end else begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
            r_cls     <= n_cls;
            r_units   <= n_units;
            r_err     <= n_err;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |=>
            (r_pending == '0) && (r_units == '0) && (r_err == u8v_pkg::STAT_OK))
        else $error("string state not cleared after last byte");

    a_sticky_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_last_byte && (r_err != u8v_pkg::STAT_OK) |=>
            $stable(r_err) && $stable(r_units))
        else $error("error or count changed after first error");

    a_idle_accum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> (r_accum == '0) && (r_cls == u8v_pkg::CLS_NONE))
        else $error("scalar state left over with no sequence open");

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_err == u8v_pkg::STAT_OK) && (o_result.unit_count != r_units) |->
            (o_result.unit_count <= i_max_units))
        else $error("unit count advanced past limit");

endmodule

/* design/utf8_validate_utf16_count_unit.sv */
// Top level: UTF-8 validation with UTF-16 unit count, byte stream in, one result per byte.
// Timing: a result is registered when its byte is accepted and shows on o_out_valid in the cycle after.
// Throughput: one byte per cycle while i_out_ready holds; the per-byte decode, scalar check
// and unit-count compare sit in one path from the string state registers back to themselves.
// The result register frees as it is taken, so input and output overlap fully.
// Reset: unit limit returns to 255, string state clears, no result is held.
module utf8_validate_utf16_count_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8v_pkg::ApbAddrW-1:0]  paddr,
    input  logic [u8v_pkg::ApbDataW-1:0]  pwdata,
    output logic [u8v_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [u8v_pkg::DataW-1:0]     i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [u8v_pkg::CountW-1:0]    o_unit_count,
    output logic                          o_string_end
);

    logic [u8v_pkg::CountW-1:0] max_units;
    logic                       accept;
    u8v_pkg::t_result           step_res;
    u8v_pkg::t_result           r_res;
    logic                       r_out_valid, n_out_valid;

    u8v_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_units (max_units)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    u8v_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_max_units (max_units),
        .o_result    (step_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_res.status;
    assign o_unit_count = r_res.unit_count;
    assign o_string_end = r_res.string_end;

endmodule

/* dv/tb_utf8_validate_utf16_count_unit.sv */
// Testbench for the UTF-8 validator with UTF-16 unit count: directed and random strings.
class utf16_count_tracker;
    logic [u8v_pkg::CountW-1:0]  max_units;
    logic [u8v_pkg::PendW-1:0]   bytes_pending;
    logic [u8v_pkg::ScalarW-1:0] scalar_accum;
    u8v_pkg::t_class             min_class;
    logic [u8v_pkg::CountW-1:0]  units_so_far;
    u8v_pkg::t_status            verdict;
    u8v_pkg::t_result            awaited_verdicts[$];
    int                          mismatches;

    function new();
        max_units  = u8v_pkg::MaxUnitsReset;
        mismatches = 0;
        clear_string();
    endfunction

    function void clear_string();
        bytes_pending = '0;
        scalar_accum  = '0;
        min_class     = u8v_pkg::CLS_NONE;
        units_so_far  = '0;
        verdict       = u8v_pkg::STAT_OK;
    endfunction

    function void write_register(input int idx, input logic [u8v_pkg::ApbDataW-1:0] value);
        if (idx == u8v_pkg::RegMaxUnits) begin
            max_units = value[u8v_pkg::CountW-1:0];
        end
    endfunction

    function logic [u8v_pkg::ScalarW-1:0] lowest_legal(input u8v_pkg::t_class cls);
        case (cls)
            u8v_pkg::CLS_2B: return 21'h000080;
            u8v_pkg::CLS_3B: return 21'h000800;
            u8v_pkg::CLS_4B: return 21'h010000;
            default:         return '0;
        endcase
    endfunction

    function void close_scalar(input logic [u8v_pkg::ScalarW-1:0] cp,
                               input u8v_pkg::t_class cls);
        logic [u8v_pkg::CountW:0] total;
        if (cp < lowest_legal(cls) || cp > u8v_pkg::ScalarMax ||
            (cp >= u8v_pkg::SurrogateLo && cp <= u8v_pkg::SurrogateHi)) begin
            verdict = u8v_pkg::STAT_BAD_ENC;
            return;
        end
        total = {1'b0, units_so_far} + ((cp > u8v_pkg::BmpMax) ? 17'd2 : 17'd1);
        if (total > {1'b0, max_units}) begin
            verdict = u8v_pkg::STAT_TOO_LONG;
            return;
        end
        units_so_far = total[u8v_pkg::CountW-1:0];
    endfunction

    function void take_byte(input logic [u8v_pkg::DataW-1:0] b, input logic last);
        u8v_pkg::t_result r;
        if (verdict == u8v_pkg::STAT_OK) begin
            if (bytes_pending == 0) begin
                if (b[7] == 1'b0) begin
                    close_scalar({13'b0, b}, u8v_pkg::CLS_NONE);
                end else if (b[7:5] == 3'b110) begin
                    scalar_accum  = {16'b0, b[4:0]};
                    bytes_pending = 2'd1;
                    min_class     = u8v_pkg::CLS_2B;
                end else if (b[7:4] == 4'b1110) begin
                    scalar_accum  = {17'b0, b[3:0]};
                    bytes_pending = 2'd2;
                    min_class     = u8v_pkg::CLS_3B;
                end else if (b[7:3] == 5'b11110) begin
                    scalar_accum  = {18'b0, b[2:0]};
                    bytes_pending = 2'd3;
                    min_class     = u8v_pkg::CLS_4B;
                end else begin
                    verdict = u8v_pkg::STAT_BAD_ENC;
                end
            end else if (b[7:6] != 2'b10) begin
                verdict = u8v_pkg::STAT_BAD_ENC;
            end else begin
                scalar_accum  = {scalar_accum[14:0], b[5:0]};
                bytes_pending = bytes_pending - 2'd1;
                if (bytes_pending == 0) begin
                    close_scalar(scalar_accum, min_class);
                    scalar_accum = '0;
                    min_class    = u8v_pkg::CLS_NONE;
                end
            end
            if (last && verdict == u8v_pkg::STAT_OK && bytes_pending != 0) begin
                verdict = u8v_pkg::STAT_BAD_ENC;
            end
        end
        r.status     = verdict;
        r.unit_count = units_so_far;
        r.string_end = last;
        awaited_verdicts.push_back(r);
        if (last) begin
            clear_string();
        end
    endfunction

    task flag_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        mismatches++;
    endtask

    task check_verdict(input logic [1:0] status, input logic [u8v_pkg::CountW-1:0] count,
                       input logic string_end);
        u8v_pkg::t_result want;
        if (awaited_verdicts.size() == 0) begin
            flag_mismatch("result with no request outstanding");
            return;
        end
        want = awaited_verdicts.pop_front();
        if (status !== want.status) begin
            flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
        end
        if (count !== want.unit_count) begin
            flag_mismatch($sformatf("unit_count %0d, want %0d", count, want.unit_count));
        end
        if (string_end !== want.string_end) begin
            flag_mismatch($sformatf("string_end %0b, want %0b", string_end, want.string_end));
        end
    endtask
endclass

module tb_utf8_validate_utf16_count_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [u8v_pkg::ApbAddrW-1:0] AddrMaxUnits = {u8v_pkg::RegMaxUnits, 2'b00};
    localparam logic [u8v_pkg::ApbAddrW-1:0] AddrUnmapped = 3'd4;
    localparam int PhaseBytes = 65;
    localparam int Phases     = 8;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [u8v_pkg::ApbAddrW-1:0] paddr       = '0;
    logic [u8v_pkg::ApbDataW-1:0] pwdata      = '0;
    logic [u8v_pkg::ApbDataW-1:0] prdata;
    logic                         pready;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_ready;
    logic [u8v_pkg::DataW-1:0]    i_data_byte = '0;
    logic                         i_last_byte = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [1:0]                   o_status;
    logic [u8v_pkg::CountW-1:0]   o_unit_count;
    logic                         o_string_end;

    utf16_count_tracker        sb = new();
    logic [u8v_pkg::DataW-1:0] utf8_bytes[$];
    int                        send_idle_pct  = 0;
    int                        recv_stall_pct = 0;

    utf8_validate_utf16_count_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_unit_count (o_unit_count),
        .o_string_end (o_string_end)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            sb.check_verdict(o_status, o_unit_count, o_string_end);
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic apb_write(input logic [u8v_pkg::ApbAddrW-1:0] addr,
                             input logic [u8v_pkg::ApbDataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(int'(addr >> 2), data);
    endtask

    task automatic verify_limit();
        logic [u8v_pkg::ApbDataW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AddrMaxUnits;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[u8v_pkg::CountW-1:0] !== sb.max_units) begin
            sb.flag_mismatch($sformatf("max_units read %0d, want %0d",
                                       got[u8v_pkg::CountW-1:0], sb.max_units));
        end
    endtask

    task automatic send_byte(input logic [u8v_pkg::DataW-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_byte(b, last);
    endtask

    task automatic send_string();
        int n;
        n = utf8_bytes.size();
        for (int k = 0; k < n; k++) begin
            send_byte(utf8_bytes[k], k == n - 1);
        end
        utf8_bytes.delete();
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic void encode_scalar(input logic [u8v_pkg::ScalarW-1:0] cp, input int len);
        case (len)
            1: utf8_bytes.push_back({1'b0, cp[6:0]});
            2: begin
                utf8_bytes.push_back({3'b110, cp[10:6]});
                utf8_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                utf8_bytes.push_back({4'b1110, cp[15:12]});
                utf8_bytes.push_back({2'b10, cp[11:6]});
                utf8_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                utf8_bytes.push_back({5'b11110, cp[20:18]});
                utf8_bytes.push_back({2'b10, cp[17:12]});
                utf8_bytes.push_back({2'b10, cp[11:6]});
                utf8_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic int add_legal_scalar();
        logic [u8v_pkg::ScalarW-1:0] cp;
        int                          len;
        len = $urandom_range(1, 4);
        case (len)
            1: cp = 21'($urandom_range(21'h7F));
            2: cp = 21'($urandom_range(21'h80, 21'h7FF));
            3: begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= u8v_pkg::SurrogateLo && cp <= u8v_pkg::SurrogateHi) begin
                    cp = cp ^ 21'h2000;
                end
            end
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        encode_scalar(cp, len);
        return len;
    endfunction

    function automatic void add_broken_scalar();
        logic [u8v_pkg::DataW-1:0] b;
        int                        len;
        case ($urandom_range(4))
            0: begin
                len = $urandom_range(2, 4);
                encode_scalar(21'($urandom_range(len == 2 ? 21'h7F
                                                 : (len == 3 ? 21'h7FF : 21'hFFFF))),
                              len);
            end
            1: encode_scalar(21'($urandom_range(u8v_pkg::SurrogateLo, u8v_pkg::SurrogateHi)),
                             3);
            2: encode_scalar(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
            3: begin
                len = $urandom_range(2, 4);
                encode_scalar(21'($urandom_range(21'h80, 21'h7FF)), 2);
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10) begin
                    b[6] = 1'b1;
                end
                utf8_bytes[utf8_bytes.size() - 1] = b;
            end
            default: begin
                b = $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                      : 8'($urandom_range(8'hF8, 8'hFF));
                utf8_bytes.push_back(b);
            end
        endcase
    endfunction

    function automatic void build_random_string();
        int scalars;
        int len;
        int broken_at;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 6)) utf8_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        scalars   = $urandom_range(1, 10);
        broken_at = ($urandom_range(99) < 30) ? $urandom_range(scalars - 1) : -1;
        len       = 1;
        for (int k = 0; k < scalars; k++) begin
            if (k == broken_at) begin
                add_broken_scalar();
                len = 1;
            end else begin
                len = add_legal_scalar();
            end
        end
        if (len > 1 && $urandom_range(99) < 10) begin
            repeat ($urandom_range(1, len - 1)) void'(utf8_bytes.pop_back());
        end
    endfunction

    task automatic run_directed();
        utf8_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                       8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        utf8_bytes = '{8'hED, 8'hA0, 8'h80, 8'h7F};
        send_string();
        utf8_bytes = '{8'hC1, 8'hBF};
        send_string();
        utf8_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();
        utf8_bytes = '{8'hC3, 8'h41};
        send_string();
        utf8_bytes = '{8'hFF};
        send_string();
        utf8_bytes = '{8'hE2, 8'h82};
        send_string();
    endtask

    task automatic program_limit(input logic [u8v_pkg::CountW-1:0] value);
        apb_write(AddrMaxUnits, {16'($urandom_range(16'hFFFF)), value});
        verify_limit();
    endtask

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        verify_limit();
        for (int ph = 0; ph < Phases; ph++) begin
            settle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            case (ph)
                0: run_directed();
                1: program_limit(16'd1);
                2: program_limit(16'hFFFF);
                3: program_limit(16'($urandom_range(2, 20)));
                4: program_limit(16'd0);
                5: begin
                    program_limit(16'($urandom_range(3, 40)));
                    apb_write(AddrUnmapped, $urandom());
                    verify_limit();
                end
                6: program_limit(16'($urandom_range(41, 16'hFFFE)));
                default: program_limit(u8v_pkg::MaxUnitsReset);
            endcase
            sent = 0;
            while (sent < PhaseBytes) begin
                build_random_string();
                sent += utf8_bytes.size();
                send_string();
            end
        end
        settle();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end
endmodule

/* sim.f */
design/u8v_pkg.sv
design/u8v_cfg.sv
design/u8v_step.sv
design/utf8_validate_utf16_count_unit.sv
dv/tb_utf8_validate_utf16_count_unit.sv
